// File: rtl/mhpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_pkg: shared types and constants for the min-heap priority queue
// Holds the queue depth, the request/result payload structs, operation and
// status codes, and the per-cell slot and command types.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    localparam int DEPTH   = 128;
    localparam int KEY_W   = 32;
    localparam int CAP_W   = 8;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int COUNT_W = 8;

    localparam logic             FUNC_INSERT  = 1'b0;
    localparam logic             FUNC_EXTRACT = 1'b1;

    localparam logic [1:0]       ST_OK        = 2'd0;
    localparam logic [1:0]       ST_FULL      = 2'd1;
    localparam logic [1:0]       ST_EMPTY     = 2'd2;

    localparam logic [KEY_W-1:0] KEY_EMPTY    = '1;
    localparam logic [CAP_W-1:0] CAP_RESET    = 8'd128;

    typedef struct packed {
        logic                    func;
        logic signed [KEY_W-1:0] key_in;
    } mhpq_req_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key_out;
        logic [1:0]              status;
        logic [COUNT_W-1:0]      count_after;
    } mhpq_rsp_t;

    // One cell's contents
    typedef struct packed {
        logic                    valid;
        logic signed [KEY_W-1:0] key;
    } mhpq_slot_t;

    // Command broadcast to every cell
    typedef struct packed {
        logic                    ins;
        logic                    ext;
        logic signed [KEY_W-1:0] key;
    } mhpq_cmd_t;

endpackage

// File: rtl/mhpq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_cell: one slot of the sorted cell chain
// Holds one key. On insert it keeps its key, takes the new key, or takes the
// key of its left neighbor; on extract it takes the key of its right neighbor.
// ----------------------------------------------------------------------------
module mhpq_cell
    import mhpq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  mhpq_cmd_t  cmd,
    input  mhpq_slot_t left_slot,
    input  logic       left_place,
    input  mhpq_slot_t right_slot,
    output mhpq_slot_t slot,
    output logic       place
);

    logic                    valid_reg;
    logic                    valid_next;
    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] key_next;

    // New key belongs at or before this slot
    assign place = !valid_reg || (cmd.key < key_reg);

    always_comb begin
        valid_next = valid_reg;
        key_next   = key_reg;
        if (cmd.ins && place) begin
            if (left_place) begin
                valid_next = left_slot.valid;
                key_next   = left_slot.key;
            end else begin
                valid_next = 1'b1;
                key_next   = cmd.key;
            end
        end else if (cmd.ext) begin
            valid_next = right_slot.valid;
            key_next   = right_slot.key;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        key_reg <= key_next;
    end

    assign slot.valid = valid_reg;
    assign slot.key   = key_reg;

endmodule

// File: rtl/mhpq_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_chain: row of cells kept in ascending key order
// Cell zero always holds the smallest key; each cell talks only to its
// two neighbors.
// ----------------------------------------------------------------------------
module mhpq_chain
    import mhpq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  mhpq_cmd_t  cmd,
    output mhpq_slot_t head
);

    mhpq_slot_t slots  [DEPTH];
    logic       places [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        mhpq_slot_t left_slot;
        logic       left_place;
        mhpq_slot_t right_slot;

        if (i == 0) begin : g_first
            assign left_slot  = '0;
            assign left_place = 1'b0;
        end else begin : g_mid
            assign left_slot  = slots[i-1];
            assign left_place = places[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_slot = '0;
        end else begin : g_inner
            assign right_slot = slots[i+1];
        end

        mhpq_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd),
            .left_slot  (left_slot),
            .left_place (left_place),
            .right_slot (right_slot),
            .slot       (slots[i]),
            .place      (places[i])
        );
    end

    assign head = slots[0];

endmodule

// File: rtl/min_heap_priority_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_heap_priority_queue_top: min priority queue over signed 32-bit keys
//
// Request channel s_*: func selects insert (key_in) or extract-minimum.
// Result channel m_*: one result per request with key_out, status and
// count_after. Insert returns key 0; extract on an empty queue returns -1
// with empty status; insert at capacity drops the key with full status.
// Config channel cfg_*: writes capacity_limit (clipped to the queue depth);
// always ready, write only while no request is in flight.
//
// Timing: the result is registered and appears in the cycle after the request
// is accepted. Throughput: one request per cycle unless results stall; every
// cell of the chain compares against the new key and shifts in the same cycle.
// Reset clears the entry count, all cell valid bits and the result valid flag,
// and sets capacity_limit to 128. No clearing pass is needed.
// When the receiver stalls, the result is held and s_ready drops until it
// is taken; a request can be accepted in the cycle the result leaves.
// ----------------------------------------------------------------------------
module min_heap_priority_queue_top
    import mhpq_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  mhpq_req_t        s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output mhpq_rsp_t        m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data
);

    logic [CAP_W-1:0] cap_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             m_valid_reg;
    mhpq_rsp_t        m_data_reg;
    mhpq_rsp_t        m_data_next;

    logic             accept;
    logic             is_ins;
    logic             full;
    logic             empty;
    logic [CMP_W-1:0] cap_ext;
    logic [CMP_W-1:0] eff_cap;
    mhpq_cmd_t        cmd;
    mhpq_slot_t       head;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign is_ins    = (s_data.func == FUNC_INSERT);

    assign cap_ext = CMP_W'(cap_reg);
    assign eff_cap = (cap_ext < CMP_W'(DEPTH)) ? cap_ext : CMP_W'(DEPTH);
    assign full    = CMP_W'(count_reg) >= eff_cap;
    assign empty   = (count_reg == '0);

    assign cmd.ins = accept && is_ins && !full;
    assign cmd.ext = accept && !is_ins && !empty;
    assign cmd.key = s_data.key_in;

    mhpq_chain u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .head    (head)
    );

    always_comb begin
        count_next = count_reg;
        if (cmd.ins) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.ext) begin
            count_next = count_reg - CNT_W'(1);
        end

        m_data_next.key_out = '0;
        m_data_next.status  = ST_OK;
        if (is_ins) begin
            if (full) begin
                m_data_next.status = ST_FULL;
            end
        end else if (empty) begin
            m_data_next.key_out = KEY_EMPTY;
            m_data_next.status  = ST_EMPTY;
        end else begin
            m_data_next.key_out = head.key;
        end
        m_data_next.count_after = COUNT_W'(count_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= CAP_RESET;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                cap_reg <= cfg_data;
            end
            count_reg <= count_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        // hold the result while the receiver stalls
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: dv/mhpq_heap_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_heap_checker: result predictor and scoreboard for the min-heap queue
// Watches the request, result and capacity channels. Each accepted request is
// run through a binary min-heap of its own, and the expected result is queued.
// Each accepted result is compared field by field with the oldest one queued.
// ----------------------------------------------------------------------------
module mhpq_heap_checker
    import mhpq_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  mhpq_req_t        s_data,
    input  logic             m_valid,
    input  logic             m_ready,
    input  mhpq_rsp_t        m_data,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data,
    output int               fail_count,
    output int               pending_count
);

    logic signed [KEY_W-1:0] heap_keys [DEPTH];
    int                      heap_len = 0;
    int                      capacity_reg = int'(CAP_RESET);
    int                      errors = 0;
    mhpq_rsp_t               pending_results [$];

    task automatic apply_heap_op(input mhpq_req_t req, output mhpq_rsp_t rsp);
        int                      pos;
        int                      up;
        int                      best;
        int                      lch;
        int                      rch;
        int                      limit;
        logic signed [KEY_W-1:0] tmp;
        rsp.key_out = '0;
        rsp.status  = ST_OK;
        limit = (capacity_reg < DEPTH) ? capacity_reg : DEPTH;
        if (req.func == FUNC_INSERT) begin
            if (heap_len >= limit) begin
                rsp.status = ST_FULL;
            end else begin
                heap_keys[heap_len] = req.key_in;
                pos = heap_len;
                heap_len++;
                // sift up while the parent is strictly larger
                while (pos != 0) begin
                    up = (pos - 1) / 2;
                    if (!(heap_keys[pos] < heap_keys[up]))
                        break;
                    tmp             = heap_keys[pos];
                    heap_keys[pos]  = heap_keys[up];
                    heap_keys[up]   = tmp;
                    pos = up;
                end
            end
        end else begin
            if (heap_len == 0) begin
                rsp.key_out = KEY_EMPTY;
                rsp.status  = ST_EMPTY;
            end else begin
                rsp.key_out = heap_keys[0];
                heap_len--;
                if (heap_len != 0) begin
                    heap_keys[0] = heap_keys[heap_len];
                    pos = 0;
                    // sift down toward the smaller child, left on a tie
                    forever begin
                        best = pos;
                        lch  = 2 * pos + 1;
                        rch  = 2 * pos + 2;
                        if (lch < heap_len && heap_keys[lch] < heap_keys[best])
                            best = lch;
                        if (rch < heap_len && heap_keys[rch] < heap_keys[best])
                            best = rch;
                        if (best == pos)
                            break;
                        tmp              = heap_keys[pos];
                        heap_keys[pos]   = heap_keys[best];
                        heap_keys[best]  = tmp;
                        pos = best;
                    end
                end
            end
        end
        rsp.count_after = COUNT_W'(heap_len);
    endtask

    always @(posedge aclk) begin
        mhpq_rsp_t want;
        mhpq_rsp_t next_rsp;
        if (!aresetn) begin
            heap_len     = 0;
            capacity_reg = int'(CAP_RESET);
            pending_results.delete();
        end else begin
            // pop before push: a result never leaves in its request's cycle
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result: key_out %0d status %0d count_after %0d",
                           m_data.key_out, m_data.status, m_data.count_after);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_data.key_out !== want.key_out) begin
                        $error("key_out: expected %0d, actual %0d",
                               want.key_out, m_data.key_out);
                        errors++;
                    end
                    if (m_data.status !== want.status) begin
                        $error("status: expected %0d, actual %0d",
                               want.status, m_data.status);
                        errors++;
                    end
                    if (m_data.count_after !== want.count_after) begin
                        $error("count_after: expected %0d, actual %0d",
                               want.count_after, m_data.count_after);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                apply_heap_op(s_data, next_rsp);
                pending_results.push_back(next_rsp);
            end
            if (cfg_valid && cfg_ready)
                capacity_reg = int'(cfg_data);
        end
        pending_count <= pending_results.size();
        fail_count    <= errors;
    end

endmodule

// File: dv/min_heap_priority_queue_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_heap_priority_queue_top_tb: stimulus and verdict for the min-heap queue
// Drives directed and random insert/extract requests across a range of
// capacity settings, with random idling on both sides, a long result stall
// and drain pauses. The checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module min_heap_priority_queue_top_tb
    import mhpq_pkg::*;
();

    localparam int HOLD_CYCLES = 300;
    localparam int NUM_PHASES  = 10;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    mhpq_req_t        s_data = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    mhpq_rsp_t        m_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_data = '0;

    int fail_count;
    int pending_count;
    bit no_idle = 1'b0;
    bit rx_hold = 1'b0;
    int hold_req = 0;

    // capacity per phase; -1 picks one at random
    int phase_cap   [NUM_PHASES] = '{128, 128, 1, 255, 5, -1, 0, 16, -1, 128};
    int phase_ins   [NUM_PHASES] = '{85, 20, 50, 90, 60, 55, 50, 50, 50, 60};
    int phase_items [NUM_PHASES] = '{200, 200, 100, 150, 100, 150, 60, 150, 150, 150};

    always #10 aclk = ~aclk;

    min_heap_priority_queue_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    mhpq_heap_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    function automatic logic signed [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 9))
            0: pick_key = 32'sh7FFF_FFFF;
            1: pick_key = 32'sh8000_0000;
            // narrow range so ties and equal children show up
            2, 3, 4: pick_key = $signed(32'($urandom_range(0, 15)) - 32'd8);
            default: pick_key = $signed(32'($urandom));
        endcase
    endfunction

    task automatic send_req(input logic func, input logic signed [KEY_W-1:0] key);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_data.func   <= func;
        s_data.key_in <= key;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    // hold off until every queued result has been taken
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    // receiver: random gap per result, plus the long stall on request
    initial begin
        int gap;
        do @(posedge aclk); while (!aresetn);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 5);
            if (gap != 0 || rx_hold) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
                while (rx_hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // count out the long receiver stall
    initial begin
        int hold_seen;
        hold_seen = 0;
        forever begin
            @(posedge aclk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                rx_hold <= 1'b0;
            end
        end
    end

    initial begin
        int cap;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty extract, key extremes, ties, overflow cases
        send_req(FUNC_EXTRACT, 32'sh0000_0000);
        send_req(FUNC_INSERT, 32'sh7FFF_FFFF);
        send_req(FUNC_INSERT, 32'sh8000_0000);
        send_req(FUNC_INSERT, 32'sh0000_0000);
        send_req(FUNC_INSERT, -32'sd1);
        send_req(FUNC_INSERT, 32'sh0000_0001);
        send_req(FUNC_INSERT, 32'shAAAA_AAAA);
        send_req(FUNC_INSERT, 32'sh5555_5555);
        send_req(FUNC_INSERT, 32'sd5);
        send_req(FUNC_INSERT, 32'sd5);
        send_req(FUNC_EXTRACT, -32'sd1);
        send_req(FUNC_EXTRACT, 32'sh7FFF_FFFF);
        send_req(FUNC_EXTRACT, 32'sh8000_0000);
        write_capacity(8'd0);
        send_req(FUNC_INSERT, 32'sd123);
        send_req(FUNC_EXTRACT, 32'sd0);
        // capacity now below the count: keys stay, inserts drop
        write_capacity(8'd3);
        send_req(FUNC_INSERT, 32'sd9);
        send_req(FUNC_INSERT, -32'sd9);
        send_req(FUNC_EXTRACT, 32'sd0);
        write_capacity(8'd255);
        send_req(FUNC_INSERT, -32'sd2);
        send_req(FUNC_EXTRACT, 32'sd0);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            cap = phase_cap[ph];
            if (cap < 0)
                cap = (ph % 2 == 0) ? $urandom_range(0, 255) : $urandom_range(1, 128);
            write_capacity(CAP_W'(cap));
            no_idle = (ph == NUM_PHASES - 1);
            if (ph == 5) begin
                // stall the receiver and keep offering requests
                @(posedge aclk);
                hold_req <= hold_req + 1;
                for (int i = 0; i < 20; i++)
                    send_req(FUNC_INSERT, pick_key());
            end
            for (int i = 0; i < phase_items[ph]; i++) begin
                if ($urandom_range(1, 100) <= phase_ins[ph])
                    send_req(FUNC_INSERT, pick_key());
                else
                    send_req(FUNC_EXTRACT, pick_key());
            end
        end

        drain();
        repeat (10) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("min_heap_priority_queue_top: match");
        end else begin
            $display("min_heap_priority_queue_top: mismatch");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("min_heap_priority_queue_top: mismatch");
        $finish;
    end

endmodule

// File: filelist.f
rtl/mhpq_pkg.sv
rtl/mhpq_cell.sv
rtl/mhpq_chain.sv
rtl/min_heap_priority_queue_top.sv
dv/mhpq_heap_checker.sv
dv/min_heap_priority_queue_top_tb.sv
